@@ design/pwli_pkg.sv @@
// ----------------------------------------------------------------------------
// pwli_pkg
// Shared types and constants for the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package pwli_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int DATA_W          = 32;
    localparam int DIV_STEPS       = 32;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    typedef enum logic
    {
        KIND_APPEND = 1'b0,
        KIND_QUERY  = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t                     kind;
        logic                      table_select;
        logic [DATA_W-1:0]         temperature;
        logic signed [DATA_W-1:0]  point_value;
    } item_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0]  interp_value;
        logic                      empty_error;
    } result_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_SEARCH,
        ST_DIFF,
        ST_MUL,
        ST_DIV,
        ST_ADJ,
        ST_DONE
    } state_t;

endpackage

@@ design/pwli_ram.sv @@
// ----------------------------------------------------------------------------
// pwli_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/piecewise_linear_table_interp.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Two breakpoint tables in RAM; appends fill a table, queries binary-search it
// and interpolate linearly between the surrounding breakpoints.
// Append: RAM write in the transfer cycle, no result.
// Query: an empty table gives an error result; otherwise the first breakpoint is read,
//   then the last (at or beyond either end the result is that breakpoint's value),
//   then a binary search with one RAM read per step (at most ceil(log2(count-1))
//   steps), then the multiply and the 32-step restoring divider.
// One item at a time; a finished query waits while the output is still full, and
//   the next item can transfer once the result is registered.
// Reset clears the entry counts and control state; table RAM is not cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp
    import pwli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);
    localparam int AW        = IDX_W + 1;

    // control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg [2];
    logic [CNT_W-1:0]   cnt_next [2];
    logic               out_valid_reg, out_valid_next;

    // datapath
    logic                sel_reg, sel_next;
    logic [DATA_W-1:0]   t_reg, t_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [IDX_W-1:0]    hi_reg, hi_next;
    logic [IDX_W-1:0]    mid_reg, mid_next;
    logic [DATA_W-1:0]   t_lo_reg, t_lo_next;
    logic [DATA_W-1:0]   t_hi_reg, t_hi_next;
    logic [DATA_W-1:0]   v_lo_reg, v_lo_next;
    logic [DATA_W-1:0]   v_hi_reg, v_hi_next;
    logic [DATA_W-1:0]   dt_reg, dt_next;
    logic [DATA_W-1:0]   dtemp_reg, dtemp_next;
    logic [DATA_W-1:0]   dymag_reg, dymag_next;
    logic                dyneg_reg, dyneg_next;
    logic [DATA_W-1:0]   div_rem_reg, div_rem_next;
    logic [DATA_W-1:0]   div_quo_reg, div_quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    logic                err_reg, err_next;
    result_t             out_data_reg, out_data_next;

    // ram ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   rd_temp;
    logic [DATA_W-1:0]   rd_value;

    // shared combinational terms
    logic                item_xfer;
    logic [CNT_W-1:0]    item_cnt;
    logic [CNT_W-1:0]    item_cnt_m1;
    logic                item_cnt_zero;
    logic                table_full;
    logic                first_hit;
    logic                last_hit;
    logic                go_low;
    logic [IDX_W-1:0]    last_span;
    logic [IDX_W:0]      last_sum;
    logic [IDX_W-1:0]    last_mid;
    logic                last_more;
    logic [IDX_W-1:0]    search_lo;
    logic [IDX_W-1:0]    search_hi;
    logic [IDX_W-1:0]    search_span;
    logic [IDX_W:0]      search_sum;
    logic [IDX_W-1:0]    search_mid;
    logic                search_more;
    logic [DATA_W:0]     dy;
    logic [DATA_W:0]     dy_neg;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W:0]     div_cand;
    logic [DATA_W:0]     div_diff;
    logic                div_fit;
    logic                div_last;
    logic [DATA_W+1:0]   adj_base;
    logic [DATA_W+1:0]   adj_quo;
    logic [DATA_W+1:0]   adj_sum;
    logic [DATA_W-1:0]   adj_sat;
    logic                out_free;

    pwli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_temp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.temperature),
        .raddr (ram_raddr),
        .rdata (rd_temp)
    );

    pwli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.point_value),
        .raddr (ram_raddr),
        .rdata (rd_value)
    );

    assign item_ready    = (state_reg == ST_IDLE);
    assign item_xfer     = item_valid && item_ready;
    assign item_cnt      = cnt_reg[item.table_select];
    assign item_cnt_m1   = item_cnt - CNT_W'(1);
    assign item_cnt_zero = (item_cnt == '0);
    assign table_full    = (item_cnt >= CNT_W'(TABLE_DEPTH));

    assign first_hit = (t_reg <= rd_temp);
    assign last_hit  = (t_reg >= rd_temp);
    assign go_low    = (t_reg < rd_temp);

    assign last_span = hi_reg - lo_reg;
    assign last_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign last_mid  = last_sum[IDX_W:1];
    assign last_more = (last_span > IDX_W'(1));

    // the compare picks which half survives
    assign search_lo   = go_low ? lo_reg : mid_reg;
    assign search_hi   = go_low ? mid_reg : hi_reg;
    assign search_span = search_hi - search_lo;
    assign search_sum  = {1'b0, search_lo} + {1'b0, search_hi};
    assign search_mid  = search_sum[IDX_W:1];
    assign search_more = (search_span > IDX_W'(1));

    assign dy     = {v_hi_reg[DATA_W-1], v_hi_reg} - {v_lo_reg[DATA_W-1], v_lo_reg};
    assign dy_neg = (DATA_W+1)'(0) - dy;
    assign prod   = dymag_reg * dt_reg;

    // restoring divide, quotient bits shift into the low word
    assign div_cand = {div_rem_reg, div_quo_reg[DATA_W-1]};
    assign div_fit  = (div_cand >= {1'b0, dtemp_reg});
    assign div_diff = div_cand - {1'b0, dtemp_reg};
    assign div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    assign adj_base = {{2{v_lo_reg[DATA_W-1]}}, v_lo_reg};
    assign adj_quo  = {2'b00, div_quo_reg};
    assign adj_sum  = dyneg_reg ? (adj_base - adj_quo) : (adj_base + adj_quo);

    always_comb
    begin
        adj_sat = adj_sum[DATA_W-1:0];
        if (!adj_sum[DATA_W+1] && (adj_sum[DATA_W:DATA_W-1] != 2'b00))
        begin
            adj_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (adj_sum[DATA_W+1] && (adj_sum[DATA_W:DATA_W-1] != 2'b11))
        begin
            adj_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
    end

    assign out_free = !out_valid_reg || result_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer && (item.kind == KIND_QUERY))
                begin
                    state_next = item_cnt_zero ? ST_DONE : ST_RD_FIRST;
                end
            end
            ST_RD_FIRST:
            begin
                state_next = first_hit ? ST_DONE : ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                if (last_hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = last_more ? ST_SEARCH : ST_DIFF;
                end
            end
            ST_SEARCH:
            begin
                state_next = search_more ? ST_SEARCH : ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = div_last ? ST_ADJ : ST_DIV;
            end
            ST_ADJ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = out_free ? ST_IDLE : ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        t_next         = t_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        t_lo_next      = t_lo_reg;
        t_hi_next      = t_hi_reg;
        v_lo_next      = v_lo_reg;
        v_hi_next      = v_hi_reg;
        dt_next        = dt_reg;
        dtemp_next     = dtemp_reg;
        dymag_next     = dymag_reg;
        dyneg_next     = dyneg_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = {item.table_select, item_cnt[IDX_W-1:0]};
        ram_raddr      = {sel_reg, lo_reg};

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = {item.table_select, IDX_W'(0)};
                if (item_xfer)
                begin
                    if (item.kind == KIND_APPEND)
                    begin
                        // a full table drops the pair
                        if (!table_full)
                        begin
                            ram_we                      = 1'b1;
                            cnt_next[item.table_select] = item_cnt + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        sel_next = item.table_select;
                        t_next   = item.temperature;
                        lo_next  = '0;
                        hi_next  = item_cnt_m1[IDX_W-1:0];
                        res_next = '0;
                        err_next = item_cnt_zero;
                    end
                end
            end
            ST_RD_FIRST:
            begin
                t_lo_next = rd_temp;
                v_lo_next = rd_value;
                res_next  = rd_value;
                ram_raddr = {sel_reg, hi_reg};
            end
            ST_RD_LAST:
            begin
                t_hi_next = rd_temp;
                v_hi_next = rd_value;
                res_next  = rd_value;
                mid_next  = last_mid;
                ram_raddr = {sel_reg, last_mid};
            end
            ST_SEARCH:
            begin
                lo_next   = search_lo;
                hi_next   = search_hi;
                mid_next  = search_mid;
                ram_raddr = {sel_reg, search_mid};
                if (go_low)
                begin
                    t_hi_next = rd_temp;
                    v_hi_next = rd_value;
                end
                else
                begin
                    t_lo_next = rd_temp;
                    v_lo_next = rd_value;
                end
            end
            ST_DIFF:
            begin
                dt_next    = t_reg - t_lo_reg;
                dtemp_next = t_hi_reg - t_lo_reg;
                dyneg_next = dy[DATA_W];
                dymag_next = dy[DATA_W] ? dy_neg[DATA_W-1:0] : dy[DATA_W-1:0];
            end
            ST_MUL:
            begin
                // dt < dtemp, so the high word is already below the divisor
                div_rem_next = prod[2*DATA_W-1:DATA_W];
                div_quo_next = prod[DATA_W-1:0];
                div_cnt_next = '0;
            end
            ST_DIV:
            begin
                div_rem_next = div_fit ? div_diff[DATA_W-1:0] : div_cand[DATA_W-1:0];
                div_quo_next = {div_quo_reg[DATA_W-2:0], div_fit};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_ADJ:
            begin
                res_next = adj_sat;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.interp_value = res_reg;
                    out_data_next.empty_error  = err_reg;
                end
            end
            default:
            begin
                ram_raddr = {sel_reg, lo_reg};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        t_reg        <= t_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        t_lo_reg     <= t_lo_next;
        t_hi_reg     <= t_hi_next;
        v_lo_reg     <= v_lo_next;
        v_hi_reg     <= v_hi_next;
        dt_reg       <= dt_next;
        dtemp_reg    <= dtemp_next;
        dymag_reg    <= dymag_next;
        dyneg_reg    <= dyneg_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_cnt_reg  <= div_cnt_next;
        res_reg      <= res_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CNT_W'(TABLE_DEPTH)) && (cnt_reg[1] <= CNT_W'(TABLE_DEPTH)))
        else $error("entry count above table depth");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lo_reg < mid_reg) && (mid_reg < hi_reg))
        else $error("search midpoint outside its interval");

    a_div_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (div_cnt_reg == '0) |->
            (dtemp_reg != '0) && (div_rem_reg < dtemp_reg))
        else $error("quotient would not fit the divider");

    a_append_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && (item.kind == KIND_APPEND) |=> (state_reg == ST_IDLE))
        else $error("append transfer left the idle state");

    a_cnt_query_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (cnt_reg[0] == $past(cnt_reg[0]))
            && (cnt_reg[1] == $past(cnt_reg[1])))
        else $error("entry count changed during a query");
`endif

endmodule
